// ----- design/xifd_pkg.sv -----
// Shared types, constants and opcode decode functions for the x86 field decoder.
package xifd_pkg;

  localparam int unsigned MAX_INSN_LEN = 15;
  localparam logic [3:0] LEN_CAP = (MAX_INSN_LEN < 15) ? 4'(MAX_INSN_LEN) : 4'd15;

  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_REPNE = 8'hf2;
  localparam logic [7:0] PFX_REP   = 8'hf3;
  localparam logic [7:0] PFX_LOCK  = 8'hf0;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_CS    = 8'h2e;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3e;
  localparam logic [7:0] ESC_0F    = 8'h0f;

  localparam logic [1:0] SEG_NONE = 2'd0;
  localparam logic [1:0] SEG_FS   = 2'd1;
  localparam logic [1:0] SEG_GS   = 2'd2;

  localparam logic [1:0] REP_NONE  = 2'd0;
  localparam logic [1:0] REP_REP   = 2'd1;
  localparam logic [1:0] REP_REPNE = 2'd2;

  // Immediate width codes; IMM_NONE marks an opcode with no immediate.
  localparam logic [2:0] IMM_S8   = 3'd0;
  localparam logic [2:0] IMM_S16  = 3'd1;
  localparam logic [2:0] IMM_S32  = 3'd2;
  localparam logic [2:0] IMM_U16  = 3'd3;
  localparam logic [2:0] IMM_NONE = 3'd4;

  typedef struct packed {
    logic [3:0]  insn_length;
    logic        two_byte_opcode;
    logic [7:0]  opcode;
    logic        has_modrm;
    logic [7:0]  modrm_byte;
    logic [7:0]  sib_byte;
    logic signed [31:0] displacement;
    logic signed [31:0] immediate;
    logic        operand_size_16;
    logic [1:0]  rep_kind;
    logic        lock_prefix;
    logic [1:0]  segment_override;
  } insn_t;

  function automatic logic needs_modrm(input logic two, input logic [7:0] op);
    logic r;
    if (two) begin
      r = (op >= 8'h40 && op <= 8'h4f) || (op >= 8'h90 && op <= 8'h9f) ||
          op == 8'ha3 || op == 8'haf || op == 8'hb0 || op == 8'hb1 ||
          op == 8'hb6 || op == 8'hb7 || op == 8'hbe || op == 8'hbf ||
          op == 8'hc0 || op == 8'hc1;
    end else if (op < 8'h40 && op[2:0] < 3'd4) begin
      r = 1'b1;
    end else begin
      r = op == 8'h69 || op == 8'h6b || op == 8'h80 || op == 8'h81 ||
          op == 8'h83 || (op >= 8'h84 && op <= 8'h8b) || op == 8'h8d ||
          op == 8'hc0 || op == 8'hc1 || (op >= 8'hd0 && op <= 8'hd3) ||
          op == 8'hc6 || op == 8'hc7 || op == 8'hf6 || op == 8'hf7 ||
          op == 8'hfe || op == 8'hff || (op >= 8'hd8 && op <= 8'hdf);
    end
    return r;
  endfunction

  function automatic logic [2:0] imm_code(input logic two, input logic [7:0] op,
                                          input logic [2:0] reg_f, input logic opsz);
    logic [2:0] vs;
    logic [2:0] r;
    vs = opsz ? IMM_S16 : IMM_S32;
    if (two) begin
      r = (op >= 8'h80 && op <= 8'h8f) ? IMM_S32 : IMM_NONE;
    end else if (op < 8'h40 && op[2:0] == 3'd4) begin
      r = IMM_S8;
    end else if (op < 8'h40 && op[2:0] == 3'd5) begin
      r = vs;
    end else if ((op >= 8'h70 && op <= 8'h7f) || (op >= 8'hb0 && op <= 8'hb7) ||
                 op == 8'h6a || op == 8'h6b || op == 8'h80 || op == 8'h83 ||
                 op == 8'ha8 || op == 8'hc0 || op == 8'hc1 || op == 8'hc6 ||
                 op == 8'heb) begin
      r = IMM_S8;
    end else if (op == 8'h69 || op == 8'h81 || op == 8'ha9 || op == 8'hc7 ||
                 (op >= 8'hb8 && op <= 8'hbf)) begin
      r = vs;
    end else if (op == 8'h68 || op == 8'he8 || op == 8'he9) begin
      r = IMM_S32;
    end else if (op == 8'hc2) begin
      r = IMM_U16;
    end else if (op == 8'hf6 && reg_f < 3'd2) begin
      r = IMM_S8;
    end else if (op == 8'hf7 && reg_f < 3'd2) begin
      r = vs;
    end else begin
      r = IMM_NONE;
    end
    return r;
  endfunction

endpackage

// ----- design/xifd_if.sv -----
// Valid/ready channel interfaces for code bytes and decoded instructions.
interface xifd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface xifd_insn_if;
  logic        valid;
  logic        ready;
  logic [3:0]  insn_length;
  logic        two_byte_opcode;
  logic [7:0]  opcode;
  logic        has_modrm;
  logic [7:0]  modrm_byte;
  logic [7:0]  sib_byte;
  logic signed [31:0] displacement;
  logic signed [31:0] immediate;
  logic        operand_size_16;
  logic [1:0]  rep_kind;
  logic        lock_prefix;
  logic [1:0]  segment_override;
  modport source (output valid, output insn_length, output two_byte_opcode, output opcode,
                  output has_modrm, output modrm_byte, output sib_byte, output displacement,
                  output immediate, output operand_size_16, output rep_kind,
                  output lock_prefix, output segment_override, input ready);
  modport sink (input valid, input insn_length, input two_byte_opcode, input opcode,
                input has_modrm, input modrm_byte, input sib_byte, input displacement,
                input immediate, input operand_size_16, input rep_kind,
                input lock_prefix, input segment_override, output ready);
endinterface

// ----- design/xifd_seq.sv -----
// Per-byte instruction parser: phase state, field capture and result formation.
module xifd_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    code_byte,
  output logic          emit,
  output xifd_pkg::insn_t result
);
  import xifd_pkg::*;

  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_ESC    = 6'b000010,
    PH_MODRM  = 6'b000100,
    PH_SIB    = 6'b001000,
    PH_DISP   = 6'b010000,
    PH_IMM    = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic        opsz, opsz_next, rep, rep_next, repne, repne_next, lock, lock_next;
  logic [1:0]  seg, seg_next;
  logic        op_two, op_two_next;
  logic [7:0]  opcode, opcode_next;
  logic        modrm_v, modrm_v_next;
  logic [7:0]  modrm, modrm_next, sib, sib_next;
  logic [31:0] disp_acc, disp_acc_next, imm_acc, imm_acc_next;
  logic [2:0]  disp_left, disp_left_next, imm_left, imm_left_next;
  logic [1:0]  imm_w, imm_w_next;

  always_comb begin
    logic       do_adv, do_fin, after_op;
    logic [2:0] ic;
    logic [2:0] plan_reg;
    logic [1:0] md;
    phase_next = phase;
    byte_count_next = (byte_count < LEN_CAP) ? byte_count + 4'd1 : byte_count;
    opsz_next = opsz; rep_next = rep; repne_next = repne; lock_next = lock;
    seg_next = seg; op_two_next = op_two; opcode_next = opcode;
    modrm_v_next = modrm_v; modrm_next = modrm; sib_next = sib;
    disp_acc_next = disp_acc; imm_acc_next = imm_acc;
    disp_left_next = disp_left; imm_left_next = imm_left; imm_w_next = imm_w;
    do_adv = 1'b0; do_fin = 1'b0; after_op = 1'b0; plan_reg = 3'd0; md = 2'd0;
    ic = IMM_NONE;

    case (phase)
      PH_PREFIX: begin
        case (code_byte)
          PFX_OPSZ:  opsz_next = 1'b1;
          PFX_REPNE: repne_next = 1'b1;
          PFX_REP:   rep_next = 1'b1;
          PFX_LOCK:  lock_next = 1'b1;
          PFX_ES, PFX_CS, PFX_SS, PFX_DS: ;
          PFX_FS:    seg_next = SEG_FS;
          PFX_GS:    seg_next = SEG_GS;
          ESC_0F:    phase_next = PH_ESC;
          default: begin
            op_two_next = 1'b0;
            opcode_next = code_byte;
            after_op = 1'b1;
          end
        endcase
      end
      PH_ESC: begin
        op_two_next = 1'b1;
        opcode_next = code_byte;
        after_op = 1'b1;
      end
      PH_MODRM: begin
        modrm_v_next = 1'b1;
        modrm_next = code_byte;
        plan_reg = code_byte[5:3];
        ic = imm_code(op_two, opcode, plan_reg, opsz);
        imm_left_next = (ic == IMM_NONE) ? 3'd0 : (ic == IMM_S8) ? 3'd1 :
                        (ic == IMM_S32) ? 3'd4 : 3'd2;
        imm_w_next = (ic == IMM_NONE) ? 2'd0 : ic[1:0];
        md = code_byte[7:6];
        if (md == 2'd3) begin
          do_adv = 1'b1;
        end else if (code_byte[2:0] == 3'd4) begin
          phase_next = PH_SIB;
        end else begin
          if (md == 2'd0 && code_byte[2:0] == 3'd5) disp_left_next = 3'd4;
          else if (md == 2'd1) disp_left_next = 3'd1;
          else if (md == 2'd2) disp_left_next = 3'd4;
          do_adv = 1'b1;
        end
      end
      PH_SIB: begin
        sib_next = code_byte;
        md = modrm[7:6];
        if (md == 2'd0 && code_byte[2:0] == 3'd5) disp_left_next = 3'd4;
        else if (md == 2'd1) disp_left_next = 3'd1;
        else if (md == 2'd2) disp_left_next = 3'd4;
        do_adv = 1'b1;
      end
      PH_DISP: begin
        disp_acc_next = {code_byte, disp_acc[31:8]};
        disp_left_next = disp_left - 3'd1;
        if (disp_left_next == 3'd0) do_adv = 1'b1;
      end
      PH_IMM: begin
        imm_acc_next = {code_byte, imm_acc[31:8]};
        imm_left_next = imm_left - 3'd1;
        if (imm_left_next == 3'd0) do_fin = 1'b1;
      end
      default: phase_next = PH_PREFIX;
    endcase

    if (after_op) begin
      if (needs_modrm(op_two_next, opcode_next)) begin
        phase_next = PH_MODRM;
      end else begin
        if (!op_two_next && opcode_next >= 8'ha0 && opcode_next <= 8'ha3)
          disp_left_next = 3'd4;
        ic = imm_code(op_two_next, opcode_next, 3'd0, opsz);
        imm_left_next = (ic == IMM_NONE) ? 3'd0 : (ic == IMM_S8) ? 3'd1 :
                        (ic == IMM_S32) ? 3'd4 : 3'd2;
        imm_w_next = (ic == IMM_NONE) ? 2'd0 : ic[1:0];
        do_adv = 1'b1;
      end
    end

    if (do_adv) begin
      if (disp_left_next != 3'd0) phase_next = PH_DISP;
      else if (imm_left_next != 3'd0) phase_next = PH_IMM;
      else do_fin = 1'b1;
    end

    emit = step && do_fin;
    result.insn_length = byte_count_next;
    result.two_byte_opcode = op_two_next;
    result.opcode = opcode_next;
    result.has_modrm = modrm_v_next;
    result.modrm_byte = modrm_next;
    result.sib_byte = sib_next;
    result.displacement = (modrm_v_next && modrm_next[7:6] == 2'd1) ?
                          {{24{disp_acc_next[31]}}, disp_acc_next[31:24]} : disp_acc_next;
    case (imm_w_next)
      IMM_S8[1:0]:  result.immediate = {{24{imm_acc_next[31]}}, imm_acc_next[31:24]};
      IMM_S16[1:0]: result.immediate = {{16{imm_acc_next[31]}}, imm_acc_next[31:16]};
      IMM_S32[1:0]: result.immediate = imm_acc_next;
      default:      result.immediate = {16'd0, imm_acc_next[31:16]};
    endcase
    result.operand_size_16 = opsz_next;
    result.rep_kind = rep_next ? REP_REP : repne_next ? REP_REPNE : REP_NONE;
    result.lock_prefix = lock_next;
    result.segment_override = seg_next;

    if (do_fin) begin
      phase_next = PH_PREFIX; byte_count_next = 4'd0;
      opsz_next = 1'b0; rep_next = 1'b0; repne_next = 1'b0; lock_next = 1'b0;
      seg_next = SEG_NONE; op_two_next = 1'b0; opcode_next = 8'd0;
      modrm_v_next = 1'b0; modrm_next = 8'd0; sib_next = 8'd0;
      disp_acc_next = 32'd0; imm_acc_next = 32'd0;
      disp_left_next = 3'd0; imm_left_next = 3'd0; imm_w_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PREFIX; byte_count <= 4'd0;
      opsz <= 1'b0; rep <= 1'b0; repne <= 1'b0; lock <= 1'b0; seg <= SEG_NONE;
      op_two <= 1'b0; opcode <= 8'd0; modrm_v <= 1'b0; modrm <= 8'd0; sib <= 8'd0;
      disp_acc <= 32'd0; imm_acc <= 32'd0;
      disp_left <= 3'd0; imm_left <= 3'd0; imm_w <= 2'd0;
    end else if (step) begin
      phase <= phase_next; byte_count <= byte_count_next;
      opsz <= opsz_next; rep <= rep_next; repne <= repne_next; lock <= lock_next;
      seg <= seg_next; op_two <= op_two_next; opcode <= opcode_next;
      modrm_v <= modrm_v_next; modrm <= modrm_next; sib <= sib_next;
      disp_acc <= disp_acc_next; imm_acc <= imm_acc_next;
      disp_left <= disp_left_next; imm_left <= imm_left_next; imm_w <= imm_w_next;
    end
  end
endmodule

// ----- design/xifd_outreg.sv -----
// Result register that holds one decoded instruction until the consumer takes it.
module xifd_outreg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  xifd_pkg::insn_t load_data,
  output logic            can_take,
  xifd_insn_if.source     insn
);
  import xifd_pkg::*;

  logic  valid;
  insn_t data;

  assign can_take = !valid || insn.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) begin
      data <= load_data;
    end
  end

  assign insn.valid = valid;
  assign insn.insn_length = data.insn_length;
  assign insn.two_byte_opcode = data.two_byte_opcode;
  assign insn.opcode = data.opcode;
  assign insn.has_modrm = data.has_modrm;
  assign insn.modrm_byte = data.modrm_byte;
  assign insn.sib_byte = data.sib_byte;
  assign insn.displacement = data.displacement;
  assign insn.immediate = data.immediate;
  assign insn.operand_size_16 = data.operand_size_16;
  assign insn.rep_kind = data.rep_kind;
  assign insn.lock_prefix = data.lock_prefix;
  assign insn.segment_override = data.segment_override;
endmodule

// ----- design/x86_instruction_field_decoder_core.sv -----
// Top level of the x86 instruction field decoder: byte parser and result register.
// Latency: the transaction that carries an instruction's last byte makes its result
// valid on the next cycle; one code byte is accepted per cycle, limited only by the
// result register when a finished instruction is still waiting to be taken.
// Reset (rst, synchronous, active high) returns the parser to the prefix phase with
// all captured fields cleared and empties the result register.
module x86_instruction_field_decoder_core (
  input  logic        clk,
  input  logic        rst,
  xifd_byte_if.sink   code,
  xifd_insn_if.source insn
);
  import xifd_pkg::*;

  logic  can_take;
  logic  step;
  logic  emit;
  insn_t result;

  // A code byte is taken whenever the result register can absorb a possible result,
  // so the parser can stall in the middle of an instruction while a result waits.
  assign code.ready = can_take;
  assign step = code.valid && can_take;

  // The parser updates its phase state for each accepted byte and forms the full
  // result in the same cycle as the byte that ends the instruction.
  xifd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .code_byte (code.code_byte),
    .emit      (emit),
    .result    (result)
  );

  // The result register separates the two handshakes: a byte can be accepted while
  // the consumer is taking the previous result in the same cycle.
  xifd_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_data (result),
    .can_take  (can_take),
    .insn      (insn)
  );
endmodule
